// File: hdl/circular_deque_top_assert.svh
// Assertion macros for the circular deque RTL, included by cdq_dpath.
// Each property is checked on the rising clock edge and ignored during reset.
`ifndef CIRCULAR_DEQUE_TOP_ASSERT_SVH
`define CIRCULAR_DEQUE_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define CDQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Trigger followed by a consequence on the next clock edge.
`define CDQ_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared constants and types of the circular double-ended queue.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH     = 16;
    localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CFG_W     = 5;
    localparam int CMD_W     = 3;
    localparam int WORD_W    = 32;
    localparam int CAP_RESET = 16;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEEK       = 3'd4;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // take the command on the input ports
        logic cfg_wr;   // load capacity, empty the queue
        logic rd_en;    // read front and rear words
    } t_ctrl_cmd;

endpackage

// File: hdl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Sequencer for the deque: accept, read back the end words, strobe result.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    output logic      o_valid,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHOW
    } t_state;

    t_state r_state;
    logic   r_valid;
    logic   w_accept;

    assign busy        = (r_state == S_READ);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = (r_state == S_IDLE) && !start;

    assign o_cmd.accept = w_accept;
    assign o_cmd.cfg_wr = i_cfg_valid && o_cfg_ready;
    assign o_cmd.rd_en  = (r_state == S_READ);

    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_valid <= 1'b0;
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_valid <= 1'b1;
                    r_state <= S_SHOW;
                end
                S_SHOW: begin
                    // overlap: the next command may transfer while the result shows
                    r_valid <= 1'b0;
                    r_state <= w_accept ? S_READ : S_IDLE;
                end
                default: begin
                    r_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/cdq_dpath.sv
// ----------------------------------------------------------------------------
// cdq_dpath
// Ring store, end pointers, element count and result registers.
// ----------------------------------------------------------------------------
`include "circular_deque_top_assert.svh"

module cdq_dpath
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl_cmd                i_cmd,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic [CFG_W-1:0]         i_cfg_capacity_in_use,
    output logic                     o_ok,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_rear_word,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    logic signed [WORD_W-1:0] r_ring [DEPTH];

    logic [CFG_W-1:0]         r_cap_reg;
    logic [PTR_W-1:0]         r_front;
    logic [PTR_W-1:0]         r_back;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ok;
    logic signed [WORD_W-1:0] r_rd_front;
    logic signed [WORD_W-1:0] r_rd_rear;

    logic [PTR_W-1:0] n_front;
    logic [PTR_W-1:0] n_back;
    logic [CNT_W-1:0] n_count;
    logic             n_ok;
    logic             w_wr_en;
    logic [PTR_W-1:0] w_wr_addr;
    logic [CNT_W-1:0] w_cap;
    logic [CNT_W-1:0] w_cfg_cap;
    logic             w_full;
    logic             w_empty;

    function automatic logic [CNT_W-1:0] eff_cap(input logic [CFG_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0) begin
            r = CNT_W'(1);
        end else if (32'(c) > 32'(DEPTH)) begin
            r = CNT_W'(DEPTH);
        end else begin
            r = CNT_W'(c);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if ((CNT_W'(p) + CNT_W'(1)) == cap) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
                                                   input logic [CNT_W-1:0] cap);
        logic [PTR_W-1:0] r;
        if (p == '0) begin
            r = PTR_W'(cap - CNT_W'(1));
        end else begin
            r = p - PTR_W'(1);
        end
        return r;
    endfunction

    assign w_cap     = eff_cap(r_cap_reg);
    assign w_cfg_cap = eff_cap(i_cfg_capacity_in_use);
    assign w_full    = (r_count == w_cap);
    assign w_empty   = (r_count == '0);

    always_comb begin
        n_front   = r_front;
        n_back    = r_back;
        n_count   = r_count;
        n_ok      = 1'b0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_front;
        unique case (i_command)
            CMD_PUSH_FRONT: begin
                if (!w_full) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_front;
                    n_front   = step_down(r_front, w_cap);
                    n_count   = r_count + CNT_W'(1);
                    n_ok      = 1'b1;
                end
            end
            CMD_PUSH_BACK: begin
                if (!w_full) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_back;
                    n_back    = step_up(r_back, w_cap);
                    n_count   = r_count + CNT_W'(1);
                    n_ok      = 1'b1;
                end
            end
            CMD_POP_FRONT: begin
                if (!w_empty) begin
                    n_front = step_up(r_front, w_cap);
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (!w_empty) begin
                    n_back  = step_down(r_back, w_cap);
                    n_count = r_count - CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            CMD_PEEK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_reg <= CFG_W'(CAP_RESET);
            r_front   <= '0;
            r_back    <= (eff_cap(CFG_W'(CAP_RESET)) == CNT_W'(1)) ? '0 : PTR_W'(1);
            r_count   <= '0;
            r_ok      <= 1'b0;
        end else if (i_cmd.cfg_wr) begin
            r_cap_reg <= i_cfg_capacity_in_use;
            r_front   <= '0;
            r_back    <= (w_cfg_cap == CNT_W'(1)) ? '0 : PTR_W'(1);
            r_count   <= '0;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
            r_ok    <= n_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_wr_en) begin
            r_ring[w_wr_addr] <= i_value;
        end
    end

    // read both ends in the cycle after the update
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_front <= r_ring[step_up(r_front, w_cap)];
            r_rd_rear  <= r_ring[step_down(r_back, w_cap)];
        end
    end

    assign o_ok         = r_ok;
    assign o_is_empty   = w_empty;
    assign o_is_full    = w_full;
    assign o_front_word = w_empty ? EMPTY_WORD : r_rd_front;
    assign o_rear_word  = w_empty ? EMPTY_WORD : r_rd_rear;

    `CDQ_ASSERT_ALWAYS(a_count_in_cap, r_count <= w_cap, "element count exceeds capacity")
    `CDQ_ASSERT_ALWAYS(a_ptr_in_ring, (CNT_W'(r_front) < w_cap) && (CNT_W'(r_back) < w_cap), "pointer outside ring")
    `CDQ_ASSERT_ALWAYS(a_empty_adjacent, !w_empty || (r_back == step_up(r_front, w_cap)), "empty queue with separated pointers")
    `CDQ_ASSERT_NEXT(a_peek_ok, i_cmd.accept && (i_command == CMD_PEEK), r_ok, "peek not reported ok")

endmodule

// File: hdl/circular_deque_top.sv
// A command transfers at a start edge; its result strobes in S_SHOW, after the S_READ state.
// A new command can transfer while the previous result shows; busy is high only in the
//   store read state, for the registered two-address read of the ring store after the pointer update.
// The receiver cannot stall: each result shows on o_valid for exactly one cycle.
// Reset (synchronous, active low): queue empty, capacity 16, store contents undefined.
// ----------------------------------------------------------------------------
// circular_deque_top
// Bounded double-ended queue of 32-bit words with a programmable capacity.
// ----------------------------------------------------------------------------
module circular_deque_top
    import cdq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [WORD_W-1:0] i_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_capacity_in_use,
    output logic                     o_valid,
    output logic                     o_ok,
    output logic signed [WORD_W-1:0] o_front_word,
    output logic signed [WORD_W-1:0] o_rear_word,
    output logic                     o_is_empty,
    output logic                     o_is_full
);

    t_ctrl_cmd w_cmd;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd)
    );

    cdq_dpath u_dpath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (w_cmd),
        .i_command             (i_command),
        .i_value               (i_value),
        .i_cfg_capacity_in_use (i_cfg_capacity_in_use),
        .o_ok                  (o_ok),
        .o_front_word          (o_front_word),
        .o_rear_word           (o_rear_word),
        .o_is_empty            (o_is_empty),
        .o_is_full             (o_is_full)
    );

endmodule
